FILE: rtl/kab_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_pkg: shared types, constants and functions
// Controller states, datapath commands and the fixed-point helpers of the
// angle/bias Kalman filter.
// ----------------------------------------------------------------------------
package kab_pkg;

  localparam int ANGLE_W = 32;
  localparam int DT_W    = 16;
  localparam int COV_W   = 48;
  localparam int CFG_W   = 47;
  localparam int CFG_IDX_W = 2;
  localparam int DIV_BITS  = 80;   // 48-bit numerator with 32 fraction bits

  localparam logic [CFG_IDX_W-1:0] CFG_Q_ANGLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Q_BIAS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE = 2'd2;

  localparam logic [CFG_W-1:0] Q_ANGLE_RST    = 47'd16777;
  localparam logic [CFG_W-1:0] Q_BIAS_RST     = 47'd50331;
  localparam logic [CFG_W-1:0] MEAS_NOISE_RST = 47'd503316;

  // 10000.0 in Q24.24
  localparam logic signed [COV_W-1:0] COV_INIT = 48'sd167772160000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_RND, ST_WB, ST_CHECK, ST_DINIT, ST_DIV, ST_DWB, ST_FIN
  } state_t;

  // multiply-accumulate operations in issue order
  typedef enum logic [3:0] {
    MOP_ANG_PRED, MOP_DT_P11, MOP_DT_INNER, MOP_QB_DT,
    MOP_K0_Y, MOP_K1_Y, MOP_K1_P00, MOP_K1_P01, MOP_K0_P00, MOP_K0_P01
  } mop_t;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] chunk;
    logic       rnd_en;
    logic       wb_en;
    mop_t       mop;
    logic       ys_en;
    logic       div_init;
    logic       div_step;
    logic       div_wb;
    logic       out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic s_zero;
  } dp_stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] x);
    if (x > 52'sd2147483647) return 32'sh7fff_ffff;
    if (x < -52'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] x);
    if (x > 52'sh0_7fff_ffff_ffff) return 48'sh7fff_ffff_ffff;
    if (x < -52'sh0_8000_0000_0000) return 48'sh8000_0000_0000;
    return x[47:0];
  endfunction

  function automatic logic signed [51:0] sx48(input logic signed [47:0] x);
    return {{4{x[47]}}, x};
  endfunction

  function automatic logic signed [51:0] sx32(input logic signed [31:0] x);
    return {{20{x[31]}}, x};
  endfunction

  function automatic logic [47:0] mag49(input logic signed [48:0] x);
    logic [48:0] n;
    n = x[48] ? (~x + 49'd1) : x;
    return n[47:0];
  endfunction

  // clamp magnitude to the signed 48-bit range, then apply the sign
  function automatic logic signed [47:0] sign_sat48(input logic [80:0] m, input logic neg);
    logic [80:0] bound;
    logic [47:0] mm;
    bound = neg ? 81'h0_8000_0000_0000 : 81'h0_7fff_ffff_ffff;
    mm = (m > bound) ? bound[47:0] : m[47:0];
    return neg ? (~mm + 48'd1) : mm;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/kab_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_in_if: sample request channel
// Measured angle, gyro rate and time step with valid/ready.
// ----------------------------------------------------------------------------
interface kab_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] measured_angle;
  logic signed [31:0] gyro_rate;
  logic [15:0]        time_step;

  modport source(output valid, measured_angle, gyro_rate, time_step, input ready);
  modport sink(input valid, measured_angle, gyro_rate, time_step, output ready);
endinterface
`default_nettype wire

FILE: rtl/kab_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_out_if: estimate request channel
// Angle and bias estimates plus status with valid/ready.
// ----------------------------------------------------------------------------
interface kab_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle_estimate;
  logic signed [31:0] bias_estimate;
  logic               status;

  modport source(output valid, angle_estimate, bias_estimate, status, input ready);
  modport sink(input valid, angle_estimate, bias_estimate, status, output ready);
endinterface
`default_nettype wire

FILE: rtl/kab_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_ctrl: filter sequencer
// Steps the datapath through predict, divide and correct for one request.
// ----------------------------------------------------------------------------
module kab_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  output      logic             out_valid,
  input  wire logic             out_ready,
  input  wire kab_pkg::dp_stat_t stat,
  output      kab_pkg::dp_cmd_t  cmd
);
  import kab_pkg::*;

  state_t     state_r, state_nxt;
  mop_t       mop_r, mop_nxt;
  logic [6:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;

  function automatic mop_t next_mop(input mop_t m);
    case (m)
      MOP_ANG_PRED: return MOP_DT_P11;
      MOP_DT_P11:   return MOP_DT_INNER;
      MOP_DT_INNER: return MOP_QB_DT;
      MOP_QB_DT:    return MOP_K0_Y;
      MOP_K0_Y:     return MOP_K1_Y;
      MOP_K1_Y:     return MOP_K1_P00;
      MOP_K1_P00:   return MOP_K1_P01;
      MOP_K1_P01:   return MOP_K0_P00;
      MOP_K0_P00:   return MOP_K0_P01;
      default:      return MOP_ANG_PRED;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mop_r       <= MOP_ANG_PRED;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mop_r       <= mop_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mop_nxt   = mop_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    cmd.mop   = mop_r;
    cmd.chunk = cnt_r[1:0];
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          mop_nxt   = MOP_ANG_PRED;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt    = cnt_r + 7'd1;
        if (cnt_r == 7'd2) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        cmd.rnd_en = 1'b1;
        state_nxt  = ST_WB;
      end
      ST_WB: begin
        cmd.wb_en = 1'b1;
        cnt_nxt   = '0;
        if (mop_r == MOP_QB_DT) begin
          state_nxt = ST_CHECK;
        end else if (mop_r == MOP_K0_P01) begin
          state_nxt = ST_FIN;
        end else begin
          mop_nxt   = next_mop(mop_r);
          state_nxt = ST_MUL;
        end
      end
      ST_CHECK: begin
        cmd.ys_en = 1'b1;
        state_nxt = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = stat.s_zero ? ST_FIN : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 7'd1;
        if (cnt_r == 7'(DIV_BITS - 1)) begin
          state_nxt = ST_DWB;
        end
      end
      ST_DWB: begin
        cmd.div_wb = 1'b1;
        cnt_nxt    = '0;
        mop_nxt    = MOP_K0_Y;
        state_nxt  = ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

FILE: rtl/kab_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_dpath: filter datapath
// State, config registers, a 48x16 multiply-accumulate unit and a dual
// restoring divider sharing one divisor.
// ----------------------------------------------------------------------------
module kab_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire kab_pkg::dp_cmd_t                cmd,
  output      kab_pkg::dp_stat_t               stat,
  input  wire logic                            cfg_we,
  input  wire logic [kab_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [kab_pkg::CFG_W-1:0]       cfg_wdata,
  input  wire logic signed [31:0]              measured_angle,
  input  wire logic signed [31:0]              gyro_rate,
  input  wire logic [15:0]                     time_step,
  output      logic signed [31:0]              angle_estimate,
  output      logic signed [31:0]              bias_estimate,
  output      logic                            status
);
  import kab_pkg::*;

  // architectural state
  logic [CFG_W-1:0]        qa_r, qb_r, rm_r;
  logic signed [31:0]      angle_r, bias_r, angle_nxt, bias_nxt;
  logic signed [COV_W-1:0] p00_r, p01_r, p10_r, p11_r;
  logic signed [COV_W-1:0] p00_nxt, p01_nxt, p10_nxt, p11_nxt;

  // working registers
  logic signed [31:0]      meas_r, rate_r;
  logic [DT_W-1:0]         dt_r;
  logic signed [COV_W-1:0] inner_r, inner_nxt, mres_r, k0_r, k1_r;
  logic [95:0]             acc_r;
  logic                    neg_r;
  logic signed [32:0]      y_r;
  logic signed [48:0]      s_r;
  logic [DIV_BITS-1:0]     dvd0_r, dvd1_r, q0_r, q1_r;
  logic [48:0]             r0_r, r1_r, ud_r;
  logic                    dneg0_r, dneg1_r, status_r;
  logic signed [31:0]      oang_r, obias_r;
  logic                    ostat_r;

  // multiplier operands
  logic signed [48:0] opa, opb;
  logic signed [32:0] rdiff;
  logic [47:0]        ua, ub;
  logic [15:0]        ubc;
  logic [63:0]        pp;
  logic [95:0]        pps, acc_nxt;
  logic               sh16;
  logic [96:0]        rsum;
  logic [80:0]        rmag;

  // divider step
  logic [49:0] rt0, rt1;
  logic        ge0, ge1, up0, up1;

  assign rdiff = {rate_r[31], rate_r} - {bias_r[31], bias_r};

  always_comb begin
    opa  = '0;
    opb  = '0;
    sh16 = 1'b0;
    case (cmd.mop)
      MOP_ANG_PRED: begin
        opa = {{16{rdiff[32]}}, rdiff};  opb = {33'd0, dt_r};  sh16 = 1'b1;
      end
      MOP_DT_P11: begin
        opa = {33'd0, dt_r};  opb = {p11_r[47], p11_r};  sh16 = 1'b1;
      end
      MOP_DT_INNER: begin
        opa = {33'd0, dt_r};  opb = {inner_r[47], inner_r};  sh16 = 1'b1;
      end
      MOP_QB_DT: begin
        opa = {2'd0, qb_r};  opb = {33'd0, dt_r};  sh16 = 1'b1;
      end
      MOP_K0_Y:   begin opa = {k0_r[47], k0_r}; opb = {{16{y_r[32]}}, y_r}; end
      MOP_K1_Y:   begin opa = {k1_r[47], k1_r}; opb = {{16{y_r[32]}}, y_r}; end
      MOP_K1_P00: begin opa = {k1_r[47], k1_r}; opb = {p00_r[47], p00_r}; end
      MOP_K1_P01: begin opa = {k1_r[47], k1_r}; opb = {p01_r[47], p01_r}; end
      MOP_K0_P00: begin opa = {k0_r[47], k0_r}; opb = {p00_r[47], p00_r}; end
      MOP_K0_P01: begin opa = {k0_r[47], k0_r}; opb = {p01_r[47], p01_r}; end
      default: ;
    endcase
  end

  assign ua = mag49(opa);
  assign ub = mag49(opb);

  always_comb begin
    case (cmd.chunk)
      2'd0:    ubc = ub[15:0];
      2'd1:    ubc = ub[31:16];
      default: ubc = ub[47:32];
    endcase
  end

  assign pp = 64'(ua) * 64'(ubc);

  always_comb begin
    case (cmd.chunk)
      2'd0:    pps = {32'd0, pp};
      2'd1:    pps = {16'd0, pp, 16'd0};
      default: pps = {pp, 32'd0};
    endcase
  end

  assign acc_nxt = ((cmd.chunk == 2'd0) ? 96'd0 : acc_r) + pps;

  // round to nearest, ties away from zero, on the magnitude
  assign rsum = {1'b0, acc_r} + (sh16 ? 97'h8000 : 97'h8000_0000);
  assign rmag = sh16 ? rsum[96:16] : {16'd0, rsum[96:32]};

  // write-back of the rounded product
  always_comb begin
    angle_nxt = angle_r;
    bias_nxt  = bias_r;
    p00_nxt   = p00_r;
    p01_nxt   = p01_r;
    p10_nxt   = p10_r;
    p11_nxt   = p11_r;
    inner_nxt = inner_r;
    case (cmd.mop)
      MOP_ANG_PRED: angle_nxt = sat32(sx32(angle_r) + sx48(mres_r));
      MOP_DT_P11: begin
        inner_nxt = sat48(sx48(mres_r) - sx48(p01_r) - sx48(p10_r) + {5'd0, qa_r});
        p01_nxt   = sat48(sx48(p01_r) - sx48(mres_r));
        p10_nxt   = sat48(sx48(p10_r) - sx48(mres_r));
      end
      MOP_DT_INNER: p00_nxt  = sat48(sx48(p00_r) + sx48(mres_r));
      MOP_QB_DT:    p11_nxt  = sat48(sx48(p11_r) + sx48(mres_r));
      MOP_K0_Y:     angle_nxt = sat32(sx32(angle_r) + sx48(mres_r));
      MOP_K1_Y:     bias_nxt  = sat32(sx32(bias_r) + sx48(mres_r));
      MOP_K1_P00:   p10_nxt  = sat48(sx48(p10_r) - sx48(mres_r));
      MOP_K1_P01:   p11_nxt  = sat48(sx48(p11_r) - sx48(mres_r));
      MOP_K0_P00:   p00_nxt  = sat48(sx48(p00_r) - sx48(mres_r));
      MOP_K0_P01:   p01_nxt  = sat48(sx48(p01_r) - sx48(mres_r));
      default: ;
    endcase
  end

  assign rt0 = {r0_r, dvd0_r[DIV_BITS-1]};
  assign rt1 = {r1_r, dvd1_r[DIV_BITS-1]};
  assign ge0 = rt0 >= {1'b0, ud_r};
  assign ge1 = rt1 >= {1'b0, ud_r};
  assign up0 = {r0_r, 1'b0} >= {1'b0, ud_r};
  assign up1 = {r1_r, 1'b0} >= {1'b0, ud_r};

  assign stat.s_zero = (s_r == 49'sd0);

  // state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r    <= Q_ANGLE_RST;
      qb_r    <= Q_BIAS_RST;
      rm_r    <= MEAS_NOISE_RST;
      angle_r <= '0;
      bias_r  <= '0;
      p00_r   <= COV_INIT;
      p01_r   <= '0;
      p10_r   <= COV_INIT;
      p11_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_Q_ANGLE:    qa_r <= cfg_wdata;
          CFG_Q_BIAS:     qb_r <= cfg_wdata;
          CFG_MEAS_NOISE: rm_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.wb_en) begin
        angle_r <= angle_nxt;
        bias_r  <= bias_nxt;
        p00_r   <= p00_nxt;
        p01_r   <= p01_nxt;
        p10_r   <= p10_nxt;
        p11_r   <= p11_nxt;
      end
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      meas_r <= measured_angle;
      rate_r <= gyro_rate;
      dt_r   <= time_step;
    end
    if (cmd.mul_en) begin
      acc_r <= acc_nxt;
      if (cmd.chunk == 2'd0) neg_r <= opa[48] ^ opb[48];
    end
    if (cmd.rnd_en) mres_r <= sign_sat48(rmag, neg_r);
    if (cmd.wb_en) inner_r <= inner_nxt;
    if (cmd.ys_en) begin
      y_r <= {meas_r[31], meas_r} - {angle_r[31], angle_r};
      s_r <= {p00_r[47], p00_r} + {2'd0, rm_r};
    end
    if (cmd.div_init) begin
      status_r <= stat.s_zero;
      dvd0_r   <= {mag49({p00_r[47], p00_r}), 32'd0};
      dvd1_r   <= {mag49({p10_r[47], p10_r}), 32'd0};
      ud_r     <= s_r[48] ? (~s_r + 49'd1) : s_r;
      r0_r     <= '0;
      r1_r     <= '0;
      q0_r     <= '0;
      q1_r     <= '0;
      dneg0_r  <= p00_r[47] ^ s_r[48];
      dneg1_r  <= p10_r[47] ^ s_r[48];
    end
    if (cmd.div_step) begin
      r0_r   <= ge0 ? 49'(rt0 - {1'b0, ud_r}) : rt0[48:0];
      r1_r   <= ge1 ? 49'(rt1 - {1'b0, ud_r}) : rt1[48:0];
      q0_r   <= {q0_r[DIV_BITS-2:0], ge0};
      q1_r   <= {q1_r[DIV_BITS-2:0], ge1};
      dvd0_r <= {dvd0_r[DIV_BITS-2:0], 1'b0};
      dvd1_r <= {dvd1_r[DIV_BITS-2:0], 1'b0};
    end
    if (cmd.div_wb) begin
      k0_r <= sign_sat48({1'b0, q0_r} + {80'd0, up0}, dneg0_r);
      k1_r <= sign_sat48({1'b0, q1_r} + {80'd0, up1}, dneg1_r);
    end
    if (cmd.out_load) begin
      oang_r  <= angle_r;
      obias_r <= bias_r;
      ostat_r <= status_r;
    end
  end

  assign angle_estimate = oang_r;
  assign bias_estimate  = obias_r;
  assign status         = ostat_r;

endmodule
`default_nettype wire

FILE: rtl/kalman_angle_bias_filter.sv
`timescale 1ns / 1ps
`default_nettype none
// Single-axis Kalman filter tracking angle and gyro bias. Each request carries
// a measured angle and gyro rate (signed Q16.16) and a time step (unsigned
// Q0.16 s) and yields one result: the updated angle and bias estimates and a
// status bit that is set when the innovation variance S came out zero and the
// correction was skipped. One request at a time is processed, through one
// shared 48x16 multiplier (each product built from 16-bit slices, then
// rounded and written back; ten products, four when S is zero) and an
// 80-step bit-serial divider forming both gains at once, unused when S is zero.
// The result sits in an output register, so a new request is accepted while
// the previous result waits. q_angle, q_bias and the measurement noise
// variance (unsigned Q24.24) are for the user to write through the cfg port
// between requests, which the block does not enforce; reset restores their
// defaults, clears angle and bias and sets P00 = P10 = 10000.0.
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter: top level
// Sequencer plus datapath with valid/ready request channels.
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  kab_in_if.sink                             in_chan,
  kab_out_if.source                          out_chan,
  input  wire logic                          cfg_we,
  input  wire logic [kab_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [kab_pkg::CFG_W-1:0]     cfg_wdata
);
  import kab_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one request through predict, divide, correct
  kab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic, filter state and config registers
  kab_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_idx        (cfg_idx),
    .cfg_wdata      (cfg_wdata),
    .measured_angle (in_chan.measured_angle),
    .gyro_rate      (in_chan.gyro_rate),
    .time_step      (in_chan.time_step),
    .angle_estimate (out_chan.angle_estimate),
    .bias_estimate  (out_chan.bias_estimate),
    .status         (out_chan.status)
  );

endmodule
`default_nettype wire

FILE: rtl/kab_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kab_checker: port-level checks
// Handshake and sequencing checks on the filter's top-level ports.
// ----------------------------------------------------------------------------
module kab_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] angle_estimate,
  input wire logic [31:0] bias_estimate,
  input wire logic        status
);

  // result held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(angle_estimate) && $stable(bias_estimate)
      && $stable(status))
    else $error("out payload changed while stalled");

  // one request in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // no result shows in the cycle after an accept unless one was waiting
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> !out_valid)
    else $error("result appeared too early");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out valid set after reset");

endmodule

bind kalman_angle_bias_filter kab_checker u_kab_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .angle_estimate (out_chan.angle_estimate),
  .bias_estimate  (out_chan.bias_estimate),
  .status         (out_chan.status)
);
`default_nettype wire
